/* sv/lfe_pkg.sv */
// Package for the lambda fractal escape-time block: number formats,
// register indexes, command and status structs, and the fixed-point helpers.
// No dependencies.
package lfe_pkg;

  // Signed Q8.24 value and a truncated product of two of them.
  typedef logic signed [31:0] q_t;
  typedef logic signed [40:0] prod_t;
  typedef logic signed [42:0] sum_t;

  localparam int IDX_W = 3;
  localparam int CFG_W = 24;
  localparam logic [IDX_W-1:0] CFG_OFFSET_X = 3'd0;
  localparam logic [IDX_W-1:0] CFG_OFFSET_Y = 3'd1;
  localparam logic [IDX_W-1:0] CFG_ZOOM     = 3'd2;
  localparam logic [IDX_W-1:0] CFG_MAX_ITER = 3'd3;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;
  localparam q_t Z_START = 32'sh0080_0000;
  localparam sum_t ESC_LIM = 43'sd67108864;
  localparam int QUO_W = 31;

  // Configuration register contents.
  typedef struct packed {
    logic signed [20:0] offset_x;
    logic signed [20:0] offset_y;
    logic [23:0]        zoom_scale;
    logic [11:0]        max_iter;
  } lfe_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic map;
    logic dinit;
    logic dstep;
    logic dstore;
    logic sel;
    logic zinit;
    logic prod;
    logic pq;
    logic cmul;
    logic sum;
    logic inc;
    logic oload;
  } lfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic esc;
    logic last;
    logic zero_lim;
  } lfe_stat_t;

  // Product of two Q8.24 values, magnitude truncated; dbl shifts by 23.
  function automatic prod_t mulq(input q_t a, input q_t b, input logic dbl);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] m;
    logic [39:0] s;
    logic        neg;
    neg = a[31] ^ b[31];
    ma  = a[31] ? 32'(-a) : 32'(a);
    mb  = b[31] ? 32'(-b) : 32'(b);
    m   = 64'(ma) * 64'(mb);
    s   = dbl ? m[62:23] : {1'b0, m[62:24]};
    return neg ? -$signed({1'b0, s}) : $signed({1'b0, s});
  endfunction

  // Saturate a wide sum to the Q8.24 range.
  function automatic q_t sat_q(input sum_t v);
    if (v > 43'(Q_MAX)) return Q_MAX;
    if (v < 43'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

endpackage

/* sv/lfe_regs.sv */
// Configuration registers of the lambda fractal block.
// Depends on lfe_pkg.
module lfe_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [lfe_pkg::IDX_W-1:0]  wr_index,
  input  logic [lfe_pkg::CFG_W-1:0]  wr_data,
  output lfe_pkg::lfe_cfg_t          cfg
);
  import lfe_pkg::*;

  // Register file, written one register per handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x   <= '0;
      cfg.offset_y   <= '0;
      cfg.zoom_scale <= 24'd65536;
      cfg.max_iter   <= 12'd50;
    end else if (wr_en) begin
      case (wr_index)
        CFG_OFFSET_X: cfg.offset_x   <= $signed(wr_data[20:0]);
        CFG_OFFSET_Y: cfg.offset_y   <= $signed(wr_data[20:0]);
        CFG_ZOOM:     cfg.zoom_scale <= wr_data[23:0];
        CFG_MAX_ITER: cfg.max_iter   <= wr_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/lfe_ctrl.sv */
// Controller of the lambda fractal block: sequences mapping, division
// and the escape loop. Depends on lfe_pkg.
module lfe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  lfe_pkg::lfe_stat_t stat,
  output lfe_pkg::lfe_cmd_t  cmd
);
  import lfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MAP, S_DINIT, S_DSTEP, S_DSTORE, S_ZINIT, S_PROD0, S_PQ0,
    S_CMUL, S_SUM, S_PROD, S_PQ, S_FIN
  } state_t;

  state_t     state;
  logic [4:0] step;
  logic       sel;
  logic       room;

  assign in_stall = (state != S_IDLE);
  assign room     = !out_valid || !out_stall;

  // Commands decoded from the current state.
  always_comb begin
    cmd        = '0;
    cmd.sel    = sel;
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.map    = (state == S_MAP);
    cmd.dinit  = (state == S_DINIT);
    cmd.dstep  = (state == S_DSTEP);
    cmd.dstore = (state == S_DSTORE);
    cmd.zinit  = (state == S_ZINIT);
    cmd.prod   = (state == S_PROD0) || (state == S_PROD);
    cmd.pq     = (state == S_PQ0) || (state == S_PQ);
    cmd.cmul   = (state == S_CMUL);
    cmd.sum    = (state == S_SUM);
    cmd.inc    = (state == S_PQ) && !stat.esc;
    cmd.oload  = (state == S_FIN) && room;
  end

  // State register and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A new result takes the output register as the old one leaves.
      if ((state == S_FIN) && room) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) state <= S_MAP;
        S_MAP: begin
          sel   <= 1'b0;
          state <= S_DINIT;
        end
        S_DINIT: begin
          step  <= '0;
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          step <= step + 5'd1;
          if (step == 5'(QUO_W - 1)) state <= S_DSTORE;
        end
        S_DSTORE: begin
          sel <= 1'b1;
          if (sel) state <= S_ZINIT;
          else     state <= S_DINIT;
        end
        S_ZINIT: state <= stat.zero_lim ? S_FIN : S_PROD0;
        S_PROD0: state <= S_PQ0;
        S_PQ0:   state <= S_CMUL;
        S_CMUL:  state <= S_SUM;
        S_SUM:   state <= S_PROD;
        S_PROD:  state <= S_PQ;
        S_PQ: begin
          if (stat.esc || stat.last) state <= S_FIN;
          else                       state <= S_CMUL;
        end
        S_FIN: begin
          if (room) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/lfe_dp.sv */
// Datapath of the lambda fractal block: coordinate mapping, shared
// restoring divider, seven product units and the iteration counter.
// Depends on lfe_pkg.
module lfe_dp #(
  parameter int WIN_W = 1024,
  parameter int WIN_H = 1024
) (
  input  logic               clk,
  input  lfe_pkg::lfe_cfg_t  cfg,
  input  lfe_pkg::lfe_cmd_t  cmd,
  output lfe_pkg::lfe_stat_t stat,
  input  logic [9:0]         pixel_x,
  input  logic [9:0]         pixel_y,
  output logic [9:0]         out_x,
  output logic [9:0]         out_y,
  output logic [11:0]        escape_count,
  output logic               draw_flag
);
  import lfe_pkg::*;

  localparam int WMAX  = (WIN_W > WIN_H) ? WIN_W : WIN_H;
  localparam int DEN_W = 24 + $clog2(WMAX + 1);
  localparam int REM_W = DEN_W + 1;
  localparam int CMP_W = (DEN_W > 33) ? DEN_W : 33;
  localparam int HALF_W = WIN_W / 2;
  localparam int HALF_H = WIN_H / 2;

  logic [9:0]          px, py;
  logic [23:0]         ax, ay;
  logic                negx, negy;
  logic [DEN_W-1:0]    denx, deny;
  logic [REM_W-1:0]    rem;
  logic [QUO_W-1:0]    quo;
  logic                dsat, dneg;
  logic [DEN_W-1:0]    den;
  q_t                  cre, cim, re, im, p, q;
  prod_t               rr, ii, ri, crep, cimq, creq, cimp;
  logic [11:0]         cnt;

  logic signed [22:0]  dx, dy;
  logic [21:0]         mx, my;
  logic [23:0]         zoom_eff;
  logic [23:0]         a_sel;
  logic [CMP_W-1:0]    a_sh;
  logic [REM_W:0]      r2;
  q_t                  c_val;
  logic [12:0]         cnt_p1;

  // Offsets of the pixel from the window centre.
  assign dx = $signed({13'd0, px}) + $signed({{2{cfg.offset_x[20]}}, cfg.offset_x})
              - 23'(HALF_W);
  assign dy = $signed({13'd0, py}) + $signed({{2{cfg.offset_y[20]}}, cfg.offset_y})
              - 23'(HALF_H);
  assign mx = dx[22] ? 22'(-dx) : dx[21:0];
  assign my = dy[22] ? 22'(-dy) : dy[21:0];
  assign zoom_eff = (cfg.zoom_scale == '0) ? 24'd1 : cfg.zoom_scale;

  // Divider operands for the coordinate in progress.
  assign a_sel = cmd.sel ? ay : ax;
  assign den   = cmd.sel ? deny : denx;
  assign a_sh  = CMP_W'({a_sel, 9'd0});
  assign r2    = {rem, 1'b0};
  assign c_val = dsat ? (dneg ? Q_MIN : Q_MAX)
                      : (dneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));

  assign cnt_p1        = {1'b0, cnt} + 13'd1;
  assign stat.esc      = (43'(rr) + 43'(ii)) > ESC_LIM;
  assign stat.last     = cnt_p1 >= {1'b0, cfg.max_iter};
  assign stat.zero_lim = (cfg.max_iter == '0);

  // Pixel capture and mapping operands.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= pixel_x;
      py <= pixel_y;
    end
    if (cmd.map) begin
      ax   <= 24'(mx) * 24'd3;
      ay   <= 24'(my) * 24'd2;
      negx <= dx[22];
      negy <= dy[22];
      denx <= DEN_W'(zoom_eff) * DEN_W'(WIN_W);
      deny <= DEN_W'(zoom_eff) * DEN_W'(WIN_H);
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.dinit) begin
      dsat <= a_sh >= CMP_W'(den);
      dneg <= cmd.sel ? negy : negx;
      rem  <= REM_W'(a_sh);
      quo  <= '0;
    end
    if (cmd.dstep) begin
      if (r2 >= (REM_W + 1)'(den)) begin
        rem <= REM_W'(r2 - (REM_W + 1)'(den));
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= REM_W'(r2);
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd.dstore) begin
      if (cmd.sel) cim <= c_val;
      else         cre <= c_val;
    end
  end

  // Escape iteration: products, p and q, products with c, new z.
  always_ff @(posedge clk) begin
    if (cmd.zinit) begin
      re  <= Z_START;
      im  <= '0;
      cnt <= '0;
    end
    if (cmd.prod) begin
      rr <= mulq(re, re, 1'b0);
      ii <= mulq(im, im, 1'b0);
      ri <= mulq(re, im, 1'b1);
    end
    if (cmd.pq) begin
      p <= sat_q(43'(re) - 43'(rr) + 43'(ii));
      q <= sat_q(43'(im) - 43'(ri));
    end
    if (cmd.cmul) begin
      crep <= mulq(cre, p, 1'b0);
      cimq <= mulq(cim, q, 1'b0);
      creq <= mulq(cre, q, 1'b0);
      cimp <= mulq(cim, p, 1'b0);
    end
    if (cmd.sum) begin
      re <= sat_q(43'(crep) - 43'(cimq));
      im <= sat_q(43'(creq) + 43'(cimp));
    end
    if (cmd.inc) cnt <= cnt + 12'd1;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.oload) begin
      out_x        <= px;
      out_y        <= py;
      escape_count <= cnt;
      draw_flag    <= cnt_p1 < {1'b0, cfg.max_iter};
    end
  end

endmodule

/* sv/lambda_fractal_escape_time.sv */
// Top level of the lambda fractal escape-time evaluator.
// Depends on lfe_pkg, lfe_regs, lfe_ctrl and lfe_dp.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   pixel_x, pixel_y
//   output   out_valid / out_stall out_x, out_y, escape_count, draw_flag
//   config   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each item maps its pixel with two 31-step restoring divisions, one per
// coordinate, then each iteration passes through the seven product units
// in the steps CMUL, SUM, PROD and PQ.
// Reset is synchronous and brings the configuration and control registers
// to their reset values; the datapath registers have no reset.
// A new item is taken while a finished result still waits in the output
// register; the block stalls its input while an item is in work.
module lambda_fractal_escape_time #(
  parameter int WIN_W = 1024,
  parameter int WIN_H = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [9:0]                pixel_x,
  input  logic [9:0]                pixel_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [9:0]                out_x,
  output logic [9:0]                out_y,
  output logic [11:0]               escape_count,
  output logic                      draw_flag,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lfe_pkg::IDX_W-1:0] cfg_index,
  input  logic [lfe_pkg::CFG_W-1:0] cfg_data
);
  import lfe_pkg::*;

  lfe_cfg_t  cfg;
  lfe_cmd_t  cmd;
  lfe_stat_t stat;

  // Registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  lfe_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfe_dp #(
    .WIN_W (WIN_W),
    .WIN_H (WIN_H)
  ) u_dp (
    .clk          (clk),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .out_x        (out_x),
    .out_y        (out_y),
    .escape_count (escape_count),
    .draw_flag    (draw_flag)
  );

endmodule
